// ===== hdl/dsched_pkg.sv =====
// Shared types, constants and helper functions of the disk request scheduler.
`timescale 1ns / 1ps
package dsched_pkg;

    localparam int QUEUE_DEPTH_DEF   = 1024;
    localparam int SECTORS_PER_TRACK = 20;
    localparam int TRACK_W           = 5;
    localparam int SECTOR_W          = 5;
    localparam int IDX_W             = 10;
    localparam int TIME_W            = 21;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int POLICY_W          = 2;
    localparam int GAP_W             = 5;

    localparam logic [TRACK_W-1:0]  START_TRACK_RST  = TRACK_W'(12);
    localparam logic [SECTOR_W-1:0] START_SECTOR_RST = SECTOR_W'(10);
    localparam logic [TIME_W-1:0]   TIME_MAX         = {TIME_W{1'b1}};

    localparam logic [POLICY_W-1:0] POL_FIFO  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_SSTF  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_SCAN  = 2'd2;
    localparam logic [POLICY_W-1:0] POL_CSCAN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEEK_TIME    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_TIME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_XFER_TIME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_TRACK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_SECTOR = 3'd5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SCHED = 1'b1;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_SERVED = 2'd1,
        ST_NONE   = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic take;
        logic do_load;
        logic pass_start;
        logic track_pass;
        logic issue;
        logic decide;
        logic set_none;
        logic mul;
        logic commit;
        logic res_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic in_op;
        logic pass_done;
        logic found;
        logic sweep;
        logic out_free;
    } stat_t;

    // sector reduced into 0..SECTORS_PER_TRACK-1 (input is below twice the count)
    function automatic logic [SECTOR_W-1:0] sec_mod(input logic [SECTOR_W-1:0] s);
        logic [SECTOR_W:0] w;
        w = {1'b0, s};
        if (w >= (SECTOR_W+1)'(SECTORS_PER_TRACK))
            w = w - (SECTOR_W+1)'(SECTORS_PER_TRACK);
        return w[SECTOR_W-1:0];
    endfunction

    function automatic logic [GAP_W-1:0] rot_gap(input logic [SECTOR_W-1:0] head,
                                                 input logic [SECTOR_W-1:0] s);
        logic [SECTOR_W+1:0] d;
        d = (SECTOR_W+2)'(sec_mod(head)) + (SECTOR_W+2)'(SECTORS_PER_TRACK)
            - (SECTOR_W+2)'(sec_mod(s));
        if (d >= (SECTOR_W+2)'(SECTORS_PER_TRACK))
            d = d - (SECTOR_W+2)'(SECTORS_PER_TRACK);
        return d[GAP_W-1:0];
    endfunction

    function automatic logic [SECTOR_W-1:0] next_sec(input logic [SECTOR_W-1:0] s);
        logic [SECTOR_W:0] w;
        w = {1'b0, sec_mod(s)} + 1'b1;
        if (w == (SECTOR_W+1)'(SECTORS_PER_TRACK))
            w = '0;
        return w[SECTOR_W-1:0];
    endfunction

endpackage

// ===== hdl/dsched_if.sv =====
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface dsched_req_if import dsched_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [TRACK_W-1:0]  req_track;
    logic [SECTOR_W-1:0] req_sector;
    modport source (output valid, operation, req_track, req_sector, input ready);
    modport sink   (input valid, operation, req_track, req_sector, output ready);
endinterface

interface dsched_res_if import dsched_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [IDX_W-1:0]    chosen_index;
    logic [TRACK_W-1:0]  chosen_track;
    logic [SECTOR_W-1:0] chosen_sector;
    logic [TIME_W-1:0]   service_time;
    modport source (output valid, status, chosen_index, chosen_track, chosen_sector,
                    service_time, input ready);
    modport sink   (input valid, status, chosen_index, chosen_track, chosen_sector,
                    service_time, output ready);
endinterface

// ===== hdl/dsched_ram.sv =====
// Generic simple dual-port RAM, registered read.
`timescale 1ns / 1ps
module dsched_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/dsched_ctrl.sv =====
// Sequencing state machine of the scheduler.
`timescale 1ns / 1ps
module dsched_ctrl import dsched_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t st,
    output cmd_t  cmd
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LOAD   = 9'b000000010,
        S_START  = 9'b000000100,
        S_PASS1  = 9'b000001000,
        S_DECIDE = 9'b000010000,
        S_PASS2  = 9'b000100000,
        S_MUL    = 9'b001000000,
        S_ADD    = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (st.in_valid)
                    state_next = (st.in_op == OP_LOAD) ? S_LOAD : S_START;
            end
            S_LOAD:
            begin
                cmd.do_load = 1'b1;
                state_next  = S_DONE;
            end
            S_START:
            begin
                cmd.pass_start = 1'b1;
                state_next     = S_PASS1;
            end
            S_PASS1:
            begin
                cmd.issue = 1'b1;
                if (st.pass_done)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                priority if (!st.found)
                begin
                    cmd.set_none = 1'b1;
                    state_next   = S_DONE;
                end
                else if (st.sweep)
                begin
                    cmd.decide     = 1'b1;
                    cmd.pass_start = 1'b1;
                    cmd.track_pass = 1'b1;
                    state_next     = S_PASS2;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_PASS2:
            begin
                cmd.issue      = 1'b1;
                cmd.track_pass = 1'b1;
                if (st.pass_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ===== hdl/dsched_dp.sv =====
// Datapath: request table, scan evaluation, timing arithmetic and result register.
`timescale 1ns / 1ps
module dsched_dp import dsched_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    dsched_req_if.sink            req,
    dsched_res_if.source          res,
    input  cmd_t                  cmd,
    output stat_t                 st
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = 1 + TRACK_W + SECTOR_W;

    // configuration
    logic [POLICY_W-1:0]   policy_reg;
    logic [CFG_DATA_W-1:0] seek_reg, sectime_reg, xfer_reg;

    // scheduler state
    logic [TRACK_W-1:0]  head_trk_reg;
    logic [SECTOR_W-1:0] head_sec_reg;
    logic                rev_reg;
    logic [CW-1:0]       count_reg, fifo_next_reg;

    // captured item
    logic [TRACK_W-1:0]  in_trk_reg;
    logic [SECTOR_W-1:0] in_sec_reg;

    // scan
    logic [CW-1:0]       rd_addr_reg;
    logic                ev_valid_reg;
    logic [AW-1:0]       ev_idx_reg;
    logic                best_v_reg;
    logic [AW-1:0]       best_idx_reg;
    logic [TRACK_W-1:0]  best_trk_reg, best_d_reg;
    logic [SECTOR_W-1:0] best_sec_reg;
    logic [GAP_W-1:0]    best_gap_reg;
    logic                any_reg, up_v_reg, dn_v_reg;
    logic [TRACK_W-1:0]  low_reg, up_reg, dn_reg, target_reg;

    // timing and result
    logic [TIME_W-1:0]   mul_reg;
    status_t             rs_status_reg;
    logic [IDX_W-1:0]    rs_idx_reg;
    logic [TRACK_W-1:0]  rs_trk_reg;
    logic [SECTOR_W-1:0] rs_sec_reg;
    logic [TIME_W-1:0]   rs_time_reg;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [TRACK_W-1:0]  out_trk_reg;
    logic [SECTOR_W-1:0] out_sec_reg;
    logic [TIME_W-1:0]   out_time_reg;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata, ram_rdata;

    logic                accept, full, can_issue, issue, sweep, hit, take;
    logic [TRACK_W-1:0]  e_trk, e_d;
    logic [SECTOR_W-1:0] e_sec;
    logic [GAP_W-1:0]    e_gap;
    logic [TRACK_W-1:0]  target_next;
    logic                rev_next;
    logic [TIME_W:0]     sum;
    logic [TIME_W-1:0]   t_sat;

    dsched_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign accept    = cmd.take && req.valid;
    assign req.ready = cmd.take;
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign can_issue = (rd_addr_reg < count_reg);
    assign issue     = cmd.issue && can_issue;
    assign sweep     = (policy_reg == POL_SCAN) || (policy_reg == POL_CSCAN);

    assign st.in_valid  = req.valid;
    assign st.in_op     = req.operation;
    assign st.pass_done = !can_issue && !ev_valid_reg;
    assign st.found     = sweep ? any_reg : best_v_reg;
    assign st.sweep     = sweep;
    assign st.out_free  = !out_valid_reg || res.ready;

    // table write: new entry on load, pending cleared on service
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = {1'b1, in_trk_reg, in_sec_reg};
        if (cmd.do_load && !full)
            ram_we = 1'b1;
        else if (cmd.commit)
        begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_reg;
            ram_wdata = {1'b0, best_trk_reg, best_sec_reg};
        end
    end

    // evaluation of the entry read last cycle
    assign e_trk = ram_rdata[SECTOR_W +: TRACK_W];
    assign e_sec = ram_rdata[SECTOR_W-1:0];
    assign hit   = ev_valid_reg && ram_rdata[EW-1];
    assign e_gap = rot_gap(head_sec_reg, e_sec);
    assign e_d   = (e_trk > head_trk_reg) ? e_trk - head_trk_reg : head_trk_reg - e_trk;

    always_comb
    begin
        take = 1'b0;
        if (hit)
        begin
            if (cmd.track_pass)
                take = (e_trk == target_reg) && (!best_v_reg || e_gap < best_gap_reg);
            else if (policy_reg == POL_FIFO)
                take = !best_v_reg;
            else if (policy_reg == POL_SSTF)
                take = !best_v_reg || e_d < best_d_reg
                       || (e_d == best_d_reg && e_gap <= best_gap_reg);
        end
    end

    // sweep direction choice
    always_comb
    begin
        target_next = up_reg;
        rev_next    = rev_reg;
        if (policy_reg == POL_CSCAN)
        begin
            if (!up_v_reg)
            begin
                target_next = low_reg;
                rev_next    = 1'b1;
            end
        end
        else if (!rev_reg)
        begin
            if (!up_v_reg)
            begin
                target_next = dn_reg;
                rev_next    = 1'b1;
            end
        end
        else if (dn_v_reg)
            target_next = dn_reg;
        else
            rev_next = 1'b0;
    end

    assign sum   = (TIME_W+1)'(mul_reg) + (TIME_W+1)'(xfer_reg)
                 + ((best_trk_reg != head_trk_reg) ? (TIME_W+1)'(seek_reg) : '0);
    assign t_sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POL_FIFO;
            seek_reg      <= '0;
            sectime_reg   <= '0;
            xfer_reg      <= '0;
            head_trk_reg  <= START_TRACK_RST;
            head_sec_reg  <= START_SECTOR_RST;
            rev_reg       <= 1'b0;
            count_reg     <= '0;
            fifo_next_reg <= '0;
            rd_addr_reg   <= '0;
            ev_valid_reg  <= 1'b0;
            best_v_reg    <= 1'b0;
            any_reg       <= 1'b0;
            up_v_reg      <= 1'b0;
            dn_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POLICY:       policy_reg   <= cfg_wdata[POLICY_W-1:0];
                    REG_SEEK_TIME:    seek_reg     <= cfg_wdata;
                    REG_SECTOR_TIME:  sectime_reg  <= cfg_wdata;
                    REG_XFER_TIME:    xfer_reg     <= cfg_wdata;
                    REG_START_TRACK:  head_trk_reg <= cfg_wdata[TRACK_W-1:0];
                    REG_START_SECTOR: head_sec_reg <= cfg_wdata[SECTOR_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.do_load && !full)
                count_reg <= count_reg + 1'b1;
            if (cmd.decide)
                rev_reg <= rev_next;
            if (cmd.commit)
            begin
                head_trk_reg <= best_trk_reg;
                head_sec_reg <= next_sec(best_sec_reg);
                if (policy_reg == POL_FIFO)
                    fifo_next_reg <= CW'(best_idx_reg) + 1'b1;
            end

            if (cmd.pass_start)
                rd_addr_reg <= (!cmd.track_pass && policy_reg == POL_FIFO)
                               ? fifo_next_reg : '0;
            else if (issue)
                rd_addr_reg <= rd_addr_reg + 1'b1;
            ev_valid_reg <= issue;

            if (cmd.pass_start)
            begin
                best_v_reg <= 1'b0;
                any_reg    <= 1'b0;
                up_v_reg   <= 1'b0;
                dn_v_reg   <= 1'b0;
            end
            else
            begin
                if (take)
                    best_v_reg <= 1'b1;
                if (hit && !cmd.track_pass && sweep)
                begin
                    any_reg <= 1'b1;
                    if (e_trk >= head_trk_reg && (!up_v_reg || e_trk < up_reg))
                        up_v_reg <= 1'b1;
                    if (e_trk <= head_trk_reg && (!dn_v_reg || e_trk > dn_reg))
                        dn_v_reg <= 1'b1;
                end
            end

            if (cmd.res_load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_trk_reg <= req.req_track;
            in_sec_reg <= req.req_sector;
        end
        ev_idx_reg <= rd_addr_reg[AW-1:0];
        if (take)
        begin
            best_idx_reg <= ev_idx_reg;
            best_trk_reg <= e_trk;
            best_sec_reg <= e_sec;
            best_gap_reg <= e_gap;
            best_d_reg   <= e_d;
        end
        if (hit && !cmd.track_pass && sweep)
        begin
            if (!any_reg || e_trk < low_reg)
                low_reg <= e_trk;
            if (e_trk >= head_trk_reg && (!up_v_reg || e_trk < up_reg))
                up_reg <= e_trk;
            if (e_trk <= head_trk_reg && (!dn_v_reg || e_trk > dn_reg))
                dn_reg <= e_trk;
        end
        if (cmd.decide)
            target_reg <= target_next;
        if (cmd.mul)
            mul_reg <= TIME_W'(best_gap_reg) * TIME_W'(sectime_reg);

        if (cmd.do_load)
        begin
            if (full)
            begin
                rs_status_reg <= ST_FULL;
                rs_idx_reg    <= '0;
                rs_trk_reg    <= '0;
                rs_sec_reg    <= '0;
            end
            else
            begin
                rs_status_reg <= ST_LOADED;
                rs_idx_reg    <= IDX_W'(count_reg);
                rs_trk_reg    <= in_trk_reg;
                rs_sec_reg    <= in_sec_reg;
            end
            rs_time_reg <= '0;
        end
        else if (cmd.set_none)
        begin
            rs_status_reg <= ST_NONE;
            rs_idx_reg    <= '0;
            rs_trk_reg    <= '0;
            rs_sec_reg    <= '0;
            rs_time_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            rs_status_reg <= ST_SERVED;
            rs_idx_reg    <= IDX_W'(best_idx_reg);
            rs_trk_reg    <= best_trk_reg;
            rs_sec_reg    <= best_sec_reg;
            rs_time_reg   <= t_sat;
        end

        if (cmd.res_load)
        begin
            out_status_reg <= rs_status_reg;
            out_idx_reg    <= rs_idx_reg;
            out_trk_reg    <= rs_trk_reg;
            out_sec_reg    <= rs_sec_reg;
            out_time_reg   <= rs_time_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.status        = out_status_reg;
    assign res.chosen_index  = out_idx_reg;
    assign res.chosen_track  = out_trk_reg;
    assign res.chosen_sector = out_sec_reg;
    assign res.service_time  = out_time_reg;
endmodule

// ===== hdl/disk_request_scheduler.sv =====
// Top level of the disk request scheduler.
//
// Usage: items enter on the req channel (valid/ready). operation 0 loads a
// (track, sector) request into the next table slot; operation 1 schedules the
// next pending request under the configured policy (fifo, shortest seek,
// scan, circular scan). Every item yields exactly one result item on the res
// channel: status, chosen index/track/sector and service time.
// Configuration: cfg_we/cfg_index/cfg_wdata write registers 0..5 (policy,
// seek, sector and transfer times, start track, start sector); the user must
// write them only while idle, which the block itself does not enforce.
// Schedule: a schedule scans the table through the single RAM read port, one
// entry per cycle (from the fifo pointer for fifo); scan and circular scan
// then make a second pass over the table for the chosen track. One item is in
// flight at a time; the next item is accepted the cycle after the result
// register loads.
// Reset: table empty, policy fifo, head at track 12 sector 10; no clearing
// pass is needed since only loaded slots are read.
// Stall: the result register holds until taken; a finished item waits in the
// controller and ready stays low until the result register frees up.
`timescale 1ns / 1ps
module disk_request_scheduler import dsched_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    dsched_req_if.sink            req,
    dsched_res_if.source          res
);
    cmd_t  cmd;
    stat_t st;

    // sequencer
    dsched_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // table, scan and timing datapath
    dsched_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .res       (res),
        .cmd       (cmd),
        .st        (st)
    );
endmodule

// ===== verif/disk_request_scheduler_tb.sv =====
// Testbench of the disk request scheduler: directed table, then random traffic.
`timescale 1ns / 1ps
module disk_request_scheduler_tb;
    import dsched_pkg::*;

    localparam int TABLE_SIZE   = 1024;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int REPORT_LIMIT = 10;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    dsched_req_if req ();
    dsched_res_if res ();

    disk_request_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .res       (res.source)
    );

    // One result item, as compared field by field.
    typedef struct {
        status_t             status;
        logic [IDX_W-1:0]    index;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] sector;
        logic [TIME_W-1:0]   svc_time;
    } outcome_t;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic                op;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] sector;
        logic                typed;     // expectation written in the row
        outcome_t            want;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } row_t;

    // Scheduler state mirrored by the predictor.
    logic [TRACK_W-1:0]  tab_track [TABLE_SIZE];
    logic [SECTOR_W-1:0] tab_sector[TABLE_SIZE];
    bit                  tab_pend  [TABLE_SIZE];
    int                  n_loaded;
    int                  fifo_ptr;
    int                  head_trk;
    int                  head_sec;
    bit                  reversed;

    // Register copies.
    logic [POLICY_W-1:0] cur_policy;
    int                  t_seek;
    int                  t_sector;
    int                  t_xfer;

    outcome_t pending_results[$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       quiet;        // no idling on either side
    bit       hold_req;     // ask the receiver for one long hold-off

    // Clock: 2 ns period.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Rotational distance from the head, sectors reduced mod track size.
    function automatic int gap_of(int sec);
        return ((head_sec % SECTORS_PER_TRACK) + SECTORS_PER_TRACK
                - (sec % SECTORS_PER_TRACK)) % SECTORS_PER_TRACK;
    endfunction

    // First pending entry on a track with the least gap.
    function automatic int nearest_on_track(int trk);
        int best;
        int bg;
        int g;
        best = -1;
        bg = 0;
        for (int i = 0; i < n_loaded; i++)
        begin
            if (tab_pend[i] && tab_track[i] == trk)
            begin
                g = gap_of(tab_sector[i]);
                if (best < 0 || g < bg)
                begin
                    best = i;
                    bg = g;
                end
            end
        end
        return best;
    endfunction

    function automatic int pick_sweep(bit circular);
        bit has_up;
        bit has_down;
        bit any;
        int up;
        int down;
        int low;
        int t;
        has_up = 0;
        has_down = 0;
        any = 0;
        up = 0;
        down = 0;
        low = 0;
        for (int i = 0; i < n_loaded; i++)
        begin
            if (tab_pend[i])
            begin
                t = tab_track[i];
                if (!any || t < low)
                    low = t;
                any = 1;
                if (t >= head_trk && (!has_up || t < up))
                begin
                    up = t;
                    has_up = 1;
                end
                if (t <= head_trk && (!has_down || t > down))
                begin
                    down = t;
                    has_down = 1;
                end
            end
        end
        if (!any)
            return -1;
        if (circular)
        begin
            if (has_up)
                return nearest_on_track(up);
            reversed = 1;
            return nearest_on_track(low);
        end
        if (!reversed)
        begin
            if (has_up)
                return nearest_on_track(up);
            reversed = 1;
            return nearest_on_track(down);
        end
        if (has_down)
            return nearest_on_track(down);
        // nothing left below: sweep turns upward again
        reversed = 0;
        return nearest_on_track(up);
    endfunction

    function automatic int pick_shortest_seek();
        int best;
        int bd;
        int bg;
        int d;
        int g;
        best = -1;
        bd = 0;
        bg = 0;
        for (int i = 0; i < n_loaded; i++)
        begin
            if (tab_pend[i])
            begin
                d = tab_track[i] > head_trk ? tab_track[i] - head_trk
                                            : head_trk - tab_track[i];
                g = gap_of(tab_sector[i]);
                // equal distance and gap: later entry wins
                if (best < 0 || d < bd || (d == bd && g <= bg))
                begin
                    best = i;
                    bd = d;
                    bg = g;
                end
            end
        end
        return best;
    endfunction

    // Expected result of one accepted item; updates the mirrored state.
    function automatic outcome_t schedule_outcome(logic op, logic [TRACK_W-1:0] trk,
                                                  logic [SECTOR_W-1:0] sec);
        outcome_t o;
        int pick;
        longint t;
        o = '{ST_NONE, '0, '0, '0, '0};
        if (op == OP_LOAD)
        begin
            if (n_loaded >= TABLE_SIZE)
            begin
                o.status = ST_FULL;
                return o;
            end
            tab_track[n_loaded] = trk;
            tab_sector[n_loaded] = sec;
            tab_pend[n_loaded] = 1;
            o = '{ST_LOADED, IDX_W'(n_loaded), trk, sec, '0};
            n_loaded++;
            return o;
        end
        pick = -1;
        case (cur_policy)
            POL_FIFO:
            begin
                for (int i = fifo_ptr; i < n_loaded; i++)
                begin
                    if (tab_pend[i])
                    begin
                        fifo_ptr = i + 1;
                        pick = i;
                        break;
                    end
                end
            end
            POL_SSTF: pick = pick_shortest_seek();
            POL_SCAN: pick = pick_sweep(0);
            default:  pick = pick_sweep(1);
        endcase
        if (pick < 0)
            return o;
        t = (tab_track[pick] != head_trk) ? t_seek : 0;
        t += longint'(gap_of(tab_sector[pick])) * t_sector + t_xfer;
        if (t > TIME_MAX)
            t = TIME_MAX;
        o = '{ST_SERVED, IDX_W'(pick), tab_track[pick], tab_sector[pick], TIME_W'(t)};
        tab_pend[pick] = 0;
        head_trk = tab_track[pick];
        head_sec = (tab_sector[pick] + 1) % SECTORS_PER_TRACK;
        return o;
    endfunction

    // Register write, only once every expected result is back.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_POLICY:       cur_policy = val[POLICY_W-1:0];
            REG_SEEK_TIME:    t_seek = int'(val);
            REG_SECTOR_TIME:  t_sector = int'(val);
            REG_XFER_TIME:    t_xfer = int'(val);
            REG_START_TRACK:  head_trk = int'(val[4:0]);
            REG_START_SECTOR: head_sec = int'(val[4:0]);
            default: ;
        endcase
    endtask

    task automatic write_times(logic [CFG_DATA_W-1:0] sk, logic [CFG_DATA_W-1:0] sc,
                               logic [CFG_DATA_W-1:0] xf);
        write_reg(REG_SEEK_TIME, sk);
        write_reg(REG_SECTOR_TIME, sc);
        write_reg(REG_XFER_TIME, xf);
    endtask

    // Offer one item; valid stays high into the next item unless a gap is drawn.
    task automatic send_item(logic op, logic [TRACK_W-1:0] trk, logic [SECTOR_W-1:0] sec,
                             bit typed, outcome_t want);
        outcome_t o;
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 31)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid = 1'b1;
        req.operation = op;
        req.req_track = trk;
        req.req_sector = sec;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        o = schedule_outcome(op, trk, sec);
        pending_results.push_back(typed ? want : o);
    endtask

    task automatic send_random(logic op, logic [TRACK_W-1:0] trk, logic [SECTOR_W-1:0] sec);
        send_item(op, trk, sec, 0, '{ST_NONE, '0, '0, '0, '0});
    endtask

    // Receiver: random stalls, quiet stretches, one long hold-off on request.
    always @(negedge clk)
    begin
        static int hold_cnt = 0;
        static bit hold_done = 0;
        if (hold_req && !hold_done)
        begin
            hold_done = 1;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            res.ready <= 1'b0;
        end
        else if (quiet)
            res.ready <= 1'b1;
        else
            res.ready <= ($urandom_range(99) >= 31);
    end

    // Result checker.
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result item: status %0d index %0d",
                             res.status, res.chosen_index);
            end
            else
            begin
                e = pending_results.pop_front();
                if (res.status !== e.status || res.chosen_index !== e.index
                    || res.chosen_track !== e.track || res.chosen_sector !== e.sector
                    || res.service_time !== e.svc_time)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("mismatch: exp st %0d idx %0d trk %0d sec %0d t %0d",
                                 e.status, e.index, e.track, e.sector, e.svc_time);
                        $display("          got st %0d idx %0d trk %0d sec %0d t %0d",
                                 res.status, res.chosen_index, res.chosen_track,
                                 res.chosen_sector, res.service_time);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("disk_request_scheduler verification failed");
            $finish;
        end
    end

    // Directed table: typed rows are read straight off the behavior.
    function automatic row_t item_row(logic op, int trk, int sec);
        return '{ROW_ITEM, op, TRACK_W'(trk), SECTOR_W'(sec), 0,
                 '{ST_NONE, '0, '0, '0, '0}, '0, '0};
    endfunction

    function automatic row_t typed_row(logic op, int trk, int sec, outcome_t w);
        row_t r;
        r = item_row(op, trk, sec);
        r.typed = 1;
        r.want = w;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
        return '{ROW_CFG, 1'b0, '0, '0, 0, '{ST_NONE, '0, '0, '0, '0},
                 idx, CFG_DATA_W'(val)};
    endfunction

    initial
    begin
        row_t rows[$];
        int n_items;
        logic op;
        logic [TRACK_W-1:0] trk;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.operation = OP_LOAD;
        req.req_track = '0;
        req.req_sector = '0;
        quiet = 0;
        hold_req = 0;
        n_loaded = 0;
        fifo_ptr = 0;
        head_trk = START_TRACK_RST;
        head_sec = START_SECTOR_RST;
        reversed = 0;
        cur_policy = POL_FIFO;
        t_seek = 0;
        t_sector = 0;
        t_xfer = 0;
        foreach (tab_pend[i])
            tab_pend[i] = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table, then loads at the field extremes (default times are zero).
        rows.push_back(typed_row(OP_SCHED, 0, 0, '{ST_NONE, '0, '0, '0, '0}));
        rows.push_back(typed_row(OP_LOAD, 0, 0, '{ST_LOADED, 10'd0, 5'd0, 5'd0, '0}));
        rows.push_back(typed_row(OP_LOAD, 31, 31, '{ST_LOADED, 10'd1, 5'd31, 5'd31, '0}));
        rows.push_back(typed_row(OP_LOAD, 12, 10, '{ST_LOADED, 10'd2, 5'd12, 5'd10, '0}));
        rows.push_back(item_row(OP_LOAD, 12, 19));
        rows.push_back(item_row(OP_SCHED, 0, 0));
        rows.push_back(item_row(OP_SCHED, 0, 0));
        // shortest seek with out-of-range sector and same-track ties
        rows.push_back(cfg_row(REG_SEEK_TIME, 65535));
        rows.push_back(cfg_row(REG_SECTOR_TIME, 65535));
        rows.push_back(cfg_row(REG_XFER_TIME, 65535));
        rows.push_back(cfg_row(REG_POLICY, POL_SSTF));
        rows.push_back(item_row(OP_LOAD, 31, 11));
        rows.push_back(item_row(OP_SCHED, 0, 0));
        rows.push_back(item_row(OP_SCHED, 0, 0));
        // scan from the top: nothing above, so it reverses
        rows.push_back(cfg_row(REG_POLICY, POL_SCAN));
        rows.push_back(cfg_row(REG_START_TRACK, 31));
        rows.push_back(cfg_row(REG_START_SECTOR, 31));
        rows.push_back(item_row(OP_LOAD, 3, 5));
        rows.push_back(item_row(OP_LOAD, 3, 25));
        rows.push_back(item_row(OP_SCHED, 0, 0));
        rows.push_back(item_row(OP_SCHED, 0, 0));
        // circular scan wraps to the lowest track
        rows.push_back(cfg_row(REG_POLICY, POL_CSCAN));
        rows.push_back(item_row(OP_LOAD, 0, 0));
        rows.push_back(item_row(OP_SCHED, 0, 0));
        rows.push_back(item_row(OP_SCHED, 0, 0));

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                @(negedge clk);
                req.valid = 1'b0;
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end
            else
                send_item(rows[i].op, rows[i].track, rows[i].sector,
                          rows[i].typed, rows[i].want);
        end
        @(negedge clk);
        req.valid = 1'b0;

        // Random traffic in chunks, each under a fresh setting.
        n_items = 0;
        for (int chunk = 0; n_items < 480; chunk++)
        begin
            req.valid = 1'b0;
            write_reg(REG_POLICY, CFG_DATA_W'(chunk % 4));
            case (chunk % 3)
                0: write_times(0, 0, 0);
                1: write_times(16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: write_times(CFG_DATA_W'($urandom_range(65535)),
                                     CFG_DATA_W'($urandom_range(65535)),
                                     CFG_DATA_W'($urandom_range(65535)));
            endcase
            if (chunk % 4 == 1)
            begin
                write_reg(REG_START_TRACK, CFG_DATA_W'($urandom_range(31)));
                write_reg(REG_START_SECTOR, CFG_DATA_W'($urandom_range(31)));
            end
            quiet = (chunk == 2);
            if (chunk == 1)
                hold_req = 1'b1;
            for (int k = 0; k < 60; k++)
            begin
                op = ($urandom_range(99) >= 55);
                // narrow track set in some chunks for same-track ties
                trk = (chunk % 2) ? TRACK_W'($urandom_range(31))
                                  : TRACK_W'(8 + $urandom_range(3));
                send_random(op, trk, SECTOR_W'($urandom_range(31)));
                n_items++;
            end
            @(negedge clk);
            req.valid = 1'b0;
        end
        quiet = 0;

        // Serve under every policy.
        for (int p = 0; p < 4; p++)
        begin
            @(negedge clk);
            req.valid = 1'b0;
            write_reg(REG_POLICY, CFG_DATA_W'(p));
            repeat (2)
                send_random(OP_SCHED, 0, 0);
        end
        @(negedge clk);
        req.valid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2200) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("disk_request_scheduler verification clean");
        else
            $display("disk_request_scheduler verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dsched_pkg.sv
hdl/dsched_if.sv
hdl/dsched_ram.sv
hdl/dsched_ctrl.sv
hdl/dsched_dp.sv
hdl/disk_request_scheduler.sv
verif/disk_request_scheduler_tb.sv
